>>> rtl/core/tmaa_pkg.sv
// Shared constants and sequencer state type for the mesh area accumulator.
`default_nettype none
package tmaa_pkg;

  localparam int unsigned COORD_WIDTH_DEF   = 24;
  localparam int unsigned FRACTION_BITS_DEF = 8;

  localparam int unsigned AREA_WIDTH = 49;
  localparam int unsigned SUM_WIDTH  = 63;

  localparam logic [AREA_WIDTH-1:0] AREA_MAX = {AREA_WIDTH{1'b1}};
  localparam logic [SUM_WIDTH-1:0]  SUM_MAX  = {SUM_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_SIDE,
    ST_LOAD,
    ST_MUL,
    ST_AREA,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

>>> rtl/core/triangle_mesh_area_accumulator.sv
// Triangle mesh area accumulator: bit-serial side lengths, Heron product and root.
// One triangle is processed at a time: a new beat is accepted only in idle, and a stalled
//   result holds the sequencer until it is taken, as the shared multiplier and root unit
//   are used in turn.
// Reset clears the sequencer, the output valid, the running sum and saturation flag.
`default_nettype none
module triangle_mesh_area_accumulator #(
  parameter int unsigned COORD_WIDTH   = tmaa_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = tmaa_pkg::FRACTION_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire signed [COORD_WIDTH-1:0]        vertex0_x,
  input  wire signed [COORD_WIDTH-1:0]        vertex0_y,
  input  wire signed [COORD_WIDTH-1:0]        vertex0_z,
  input  wire signed [COORD_WIDTH-1:0]        vertex1_x,
  input  wire signed [COORD_WIDTH-1:0]        vertex1_y,
  input  wire signed [COORD_WIDTH-1:0]        vertex1_z,
  input  wire signed [COORD_WIDTH-1:0]        vertex2_x,
  input  wire signed [COORD_WIDTH-1:0]        vertex2_y,
  input  wire signed [COORD_WIDTH-1:0]        vertex2_z,
  input  wire                                 last_triangle,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [tmaa_pkg::AREA_WIDTH-1:0]     triangle_area,
  output logic [tmaa_pkg::SUM_WIDTH-1:0]      running_area,
  output logic                                total_final,
  output logic                                total_saturated
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned DW   = CW + 1;              // edge component magnitude
  localparam int unsigned SQW  = CW + 2;              // side length width
  localparam int unsigned QW   = CW + 3;              // Heron factor magnitude
  localparam int unsigned FW   = CW + 5;              // signed factor width
  localparam int unsigned SH   = (4 * FRACTION_BITS <= 32) ? 32 - 4 * FRACTION_BITS : 0;
  localparam int unsigned RSH  = (4 * FRACTION_BITS <= 32) ? 2 : 2 * FRACTION_BITS - 14;
  localparam int unsigned PW   = 4 * QW + SH;         // product / radicand width
  localparam int unsigned RTW  = PW / 2;              // root width
  localparam int unsigned RW   = RTW + 2;             // remainder width
  localparam int unsigned AW   = tmaa_pkg::AREA_WIDTH;
  localparam int unsigned SW   = tmaa_pkg::SUM_WIDTH;
  localparam int unsigned EXW  = RTW + AW;
  localparam int unsigned CNTW = $clog2(RTW + 1);

  tmaa_pkg::state_t state, state_next;

  // captured triangle
  logic signed [CW-1:0] vtx [9];
  logic                 last_q;

  // sequencing indices
  logic [1:0] comp, edge_idx, mstep;
  logic [CNTW-1:0] cnt;

  // shift-add multiplier
  logic [PW-1:0] acc, mcand;
  logic [QW-1:0] mplier;
  logic [PW-1:0] acc_step;

  // restoring square root
  logic [PW-1:0]  rad;
  logic [RW-1:0]  rem;
  logic [RTW-1:0] root;
  logic [RW-1:0]  rem_sh, trial;
  logic           take;
  logic [RW-1:0]  rem_step;
  logic [RTW-1:0] root_step;

  logic [SQW-1:0] side [3];

  // running total
  logic [SW-1:0] area_sum;
  logic          sum_ovf;

  logic in_fire, out_fire, fin_fire, last_step;

  assign in_stall  = (state != tmaa_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign fin_fire  = (state == tmaa_pkg::ST_FINISH) && (!out_valid || !out_stall);
  assign last_step = (cnt == CNTW'(1));

  // edge component magnitude for the next square
  function automatic logic [DW-1:0] comp_mag(input logic signed [CW-1:0] p,
                                             input logic signed [CW-1:0] q);
    logic signed [DW-1:0] d;
    begin
      d = DW'(q) - DW'(p);
      comp_mag = d[DW-1] ? DW'(-d) : d;
    end
  endfunction

  logic [1:0]    sel_edge, sel_comp;
  logic [DW-1:0] dmag;
  always_comb begin
    // edges a: v0->v2, b: v0->v1, c: v1->v2
    case (sel_edge)
      2'd0:    dmag = comp_mag(vtx[4'(sel_comp)], vtx[4'd6 + 4'(sel_comp)]);
      2'd1:    dmag = comp_mag(vtx[4'(sel_comp)], vtx[4'd3 + 4'(sel_comp)]);
      default: dmag = comp_mag(vtx[4'd3 + 4'(sel_comp)], vtx[4'd6 + 4'(sel_comp)]);
    endcase
  end

  // choose which component is loaded next
  always_comb begin
    sel_edge = edge_idx;
    sel_comp = comp + 2'd1;
    if (state == tmaa_pkg::ST_SIDE) begin
      sel_edge = edge_idx + 2'd1;
      sel_comp = 2'd0;
    end
  end

  // Heron factors from the three sides
  logic signed [FW-1:0] fa, fb, fc;
  logic signed [FW-1:0] fs [4];
  logic [QW-1:0]        fm [4];
  always_comb begin
    fa = FW'(side[0]);
    fb = FW'(side[1]);
    fc = FW'(side[2]);
    fs[0] = fa + fb + fc;
    fs[1] = fb + fc - fa;
    fs[2] = fa + fc - fb;
    fs[3] = fa + fb - fc;
    for (int i = 0; i < 4; i++) begin
      fm[i] = fs[i][FW-1] ? QW'(-fs[i]) : QW'(fs[i]);
    end
  end

  // one multiplier bit and one root bit per cycle
  always_comb begin
    acc_step  = mplier[0] ? acc + mcand : acc;
    rem_sh    = {rem[RW-3:0], rad[PW-1:PW-2]};
    trial     = {root, 2'b01};
    take      = (rem_sh >= trial);
    rem_step  = take ? rem_sh - trial : rem_sh;
    root_step = {root[RTW-2:0], take};
  end

  // area and saturating sum
  logic [RTW-1:0] root_shr;
  logic [AW-1:0]  area;
  logic [SW:0]    sum_wide;
  logic [SW-1:0]  sum_new;
  logic           ovf_new;
  always_comb begin
    root_shr = root >> RSH;
    area     = (EXW'(root_shr) > EXW'(tmaa_pkg::AREA_MAX)) ? tmaa_pkg::AREA_MAX
                                                           : AW'(root_shr);
    sum_wide = {1'b0, area_sum} + (SW + 1)'(area);
    sum_new  = sum_wide[SW] ? tmaa_pkg::SUM_MAX : sum_wide[SW-1:0];
    ovf_new  = sum_ovf || sum_wide[SW];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tmaa_pkg::ST_IDLE:   if (in_fire) state_next = tmaa_pkg::ST_SQ;
      tmaa_pkg::ST_SQ:     if (last_step && comp == 2'd2) state_next = tmaa_pkg::ST_SIDE;
      tmaa_pkg::ST_SIDE: begin
        if (last_step) begin
          state_next = (edge_idx == 2'd2) ? tmaa_pkg::ST_LOAD : tmaa_pkg::ST_SQ;
        end
      end
      tmaa_pkg::ST_LOAD:   state_next = tmaa_pkg::ST_MUL;
      tmaa_pkg::ST_MUL:    if (last_step && mstep == 2'd2) state_next = tmaa_pkg::ST_AREA;
      tmaa_pkg::ST_AREA:   if (last_step) state_next = tmaa_pkg::ST_FINISH;
      tmaa_pkg::ST_FINISH: if (fin_fire) state_next = tmaa_pkg::ST_IDLE;
      default:             state_next = tmaa_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tmaa_pkg::ST_IDLE;
      out_valid <= 1'b0;
      area_sum  <= '0;
      sum_ovf   <= 1'b0;
    end else begin
      state <= state_next;
      if (fin_fire) begin
        out_valid <= 1'b1;
        area_sum  <= last_q ? '0 : sum_new;
        sum_ovf   <= last_q ? 1'b0 : ovf_new;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      tmaa_pkg::ST_IDLE: begin
        if (in_fire) begin
          vtx[0] <= vertex0_x; vtx[1] <= vertex0_y; vtx[2] <= vertex0_z;
          vtx[3] <= vertex1_x; vtx[4] <= vertex1_y; vtx[5] <= vertex1_z;
          vtx[6] <= vertex2_x; vtx[7] <= vertex2_y; vtx[8] <= vertex2_z;
          last_q   <= last_triangle;
          edge_idx <= 2'd0;
          comp     <= 2'd0;
          acc      <= '0;
          mcand    <= PW'(comp_mag(vertex0_x, vertex2_x));
          mplier   <= QW'(comp_mag(vertex0_x, vertex2_x));
          cnt      <= CNTW'(QW);
        end
      end
      tmaa_pkg::ST_SQ: begin
        // accumulate d*d onto the running sum of squares
        acc    <= acc_step;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - CNTW'(1);
        if (last_step) begin
          if (comp == 2'd2) begin
            rad  <= acc_step << (PW - 2 * SQW);
            rem  <= '0;
            root <= '0;
            cnt  <= CNTW'(SQW);
          end else begin
            comp   <= comp + 2'd1;
            mcand  <= PW'(dmag);
            mplier <= QW'(dmag);
            cnt    <= CNTW'(QW);
          end
        end
      end
      tmaa_pkg::ST_SIDE: begin
        rad  <= rad << 2;
        rem  <= rem_step;
        root <= root_step;
        cnt  <= cnt - CNTW'(1);
        if (last_step) begin
          side[edge_idx] <= root_step[SQW-1:0];
          edge_idx       <= edge_idx + 2'd1;
          comp           <= 2'd0;
          acc            <= '0;
          mcand          <= PW'(dmag);
          mplier         <= QW'(dmag);
          cnt            <= CNTW'(QW);
        end
      end
      tmaa_pkg::ST_LOAD: begin
        acc    <= '0;
        mcand  <= PW'(fm[0]);
        mplier <= fm[1];
        mstep  <= 2'd0;
        cnt    <= CNTW'(QW);
      end
      tmaa_pkg::ST_MUL: begin
        // chain the four factors through the shared multiplier
        acc    <= acc_step;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - CNTW'(1);
        if (last_step) begin
          if (mstep == 2'd2) begin
            rad  <= acc_step << SH;
            rem  <= '0;
            root <= '0;
            cnt  <= CNTW'(RTW);
          end else begin
            mstep  <= mstep + 2'd1;
            acc    <= '0;
            mcand  <= acc_step;
            mplier <= fm[mstep + 2'd2];
            cnt    <= CNTW'(QW);
          end
        end
      end
      tmaa_pkg::ST_AREA: begin
        rad  <= rad << 2;
        rem  <= rem_step;
        root <= root_step;
        cnt  <= cnt - CNTW'(1);
      end
      tmaa_pkg::ST_FINISH: begin
        if (fin_fire) begin
          triangle_area   <= area;
          running_area    <= sum_new;
          total_final     <= last_q;
          total_saturated <= ovf_new;
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && total_saturated |-> running_area == tmaa_pkg::SUM_MAX)
    else $error("saturated total below maximum");

  a_sum_covers_area: assert property (@(posedge clk) disable iff (rst)
    out_valid && !total_saturated |-> running_area >= SW'(triangle_area))
    else $error("running total smaller than triangle area");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fin_fire && last_q |=> area_sum == '0 && !sum_ovf)
    else $error("accumulator not cleared after last triangle");

  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == tmaa_pkg::ST_SQ && comp == 2'd0 && edge_idx == 2'd0)
    else $error("sequencer did not start on first component");

endmodule
`default_nettype wire
